/* src/categorical_sampler_top_defines.svh */
// Assertion macros shared by the categorical sampler checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CATEGORICAL_SAMPLER_TOP_DEFINES_SVH
`define CATEGORICAL_SAMPLER_TOP_DEFINES_SVH

// Assert a property on a named clock, disabled while the named reset is low.
`define CS_ASSERT_AT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
	else $error(msg);

// Same, on the default clk and arst_n of the including module.
`define CS_ASSERT(label, prop, msg) `CS_ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

/* src/cs_pkg.sv */
// Shared types and constants of the categorical sampler.
// No dependencies; used by every other file of the block but the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

package cs_pkg;

	localparam int CMD_W         = 2;
	localparam int CLASS_W       = 6;
	localparam int WEIGHT_W      = 16;
	localparam int PREFIX_W      = 17;
	localparam int COUNT_W       = 32;
	localparam int NUM_CLASSES_W = 7;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 3;
	localparam int REG_IDX_W     = ADDR_W - 2;

	localparam logic [PREFIX_W-1:0]      PREFIX_ONE      = 17'h10000;
	localparam logic [COUNT_W-1:0]       COUNT_MAX       = '1;
	localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RST = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_DRAW  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_CLASSES = 1'b0
	} reg_idx_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan;
		logic pick;
		logic load_wr;
		logic clr_start;
		logic clr_step;
		logic cnt_wr;
		logic push;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             load_ok;
		logic             hit;
		logic             clr_done;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/cs_if.sv */
// Request and response channel interfaces of the categorical sampler.
// Depends on cs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cs_req_if
	import cs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [CLASS_W-1:0]  class_index;
	logic [WEIGHT_W-1:0] weight;
	logic [WEIGHT_W-1:0] uniform;

	modport source (output valid, cmd, class_index, weight, uniform, input ready);
	modport sink (input valid, cmd, class_index, weight, uniform, output ready);
endinterface

interface cs_rsp_if
	import cs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] chosen_class;
	logic [COUNT_W-1:0] class_count;

	modport source (output valid, chosen_class, class_count, input ready);
	modport sink (input valid, chosen_class, class_count, output ready);
endinterface

`default_nettype wire

/* src/categorical_sampler_top.sv */
// Categorical sampler: a load passes decode, a prefix read and a prefix write,
// a clear decode and a sweep of the hit-count memory, cmd 3 decode only. A draw
// scans from class 0 up to the chosen class, the last active one at the latest:
// the prefix table's read port is swept one entry per cycle. One item is in
// work at a time; the result register lets the next item be accepted while a
// result waits. After reset the hit-count memory is swept to zero with req.ready low.
`timescale 1ns / 1ps
`default_nettype none

module categorical_sampler_top
	import cs_pkg::*;
#(
	parameter int MAX_CLASSES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	cs_req_if.sink                 req,
	cs_rsp_if.source               rsp
);

	logic [NUM_CLASSES_W-1:0] num_classes;
	dp_cmd_t                  dp_cmd;
	dp_status_t               dp_status;

	cs_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.num_classes (num_classes)
	);

	cs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	cs_dp #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.status         (dp_status),
		.num_classes    (num_classes),
		.in_cmd         (req.cmd),
		.in_class_index (req.class_index),
		.in_weight      (req.weight),
		.in_uniform     (req.uniform),
		.chosen_class   (rsp.chosen_class),
		.class_count    (rsp.class_count)
	);

endmodule

`default_nettype wire

/* src/cs_regs.sv */
// APB register file of the categorical sampler: holds num_classes.
// Depends on cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cs_regs
	import cs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [ADDR_W-1:0]        paddr,
	input  wire logic [DATA_W-1:0]        pwdata,
	output logic      [DATA_W-1:0]        prdata,
	output logic                          pready,
	output logic      [NUM_CLASSES_W-1:0] num_classes
);

	logic [NUM_CLASSES_W-1:0] num_classes_q;
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_RST;
		end else if (wr_en && (reg_idx == REG_NUM_CLASSES)) begin
			num_classes_q <= pwdata[NUM_CLASSES_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NUM_CLASSES: prdata = DATA_W'(num_classes_q);
			default:         prdata = '0;
		endcase
	end

	assign num_classes = num_classes_q;

endmodule

`default_nettype wire

/* src/cs_dp.sv */
// Datapath of the categorical sampler: prefix-sum and hit-count memories,
// scan pipeline, saturating arithmetic and the result register. Depends on cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cs_dp
	import cs_pkg::*;
#(
	parameter int MAX_CLASSES = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_cmd_t                  cmd,
	output dp_status_t                    status,
	input  wire logic [NUM_CLASSES_W-1:0] num_classes,
	input  wire logic [CMD_W-1:0]         in_cmd,
	input  wire logic [CLASS_W-1:0]       in_class_index,
	input  wire logic [WEIGHT_W-1:0]      in_weight,
	input  wire logic [WEIGHT_W-1:0]      in_uniform,
	output logic      [CLASS_W-1:0]       chosen_class,
	output logic      [COUNT_W-1:0]       class_count
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int MAXN_W = $clog2(MAX_CLASSES + 1);
	localparam int NW = (NUM_CLASSES_W > MAXN_W) ? NUM_CLASSES_W : MAXN_W;
	localparam int SUM_W = PREFIX_W + 1;
	localparam int unsigned MAX_U = MAX_CLASSES;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_CLASSES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLASSES - 1);

	// captured item
	logic [CMD_W-1:0]    op_q;
	logic [CLASS_W-1:0]  idx_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [WEIGHT_W-1:0] uniform_q;

	logic [PREFIX_W-1:0] prefix_mem [MAX_CLASSES];
	logic [PREFIX_W-1:0] prefix_rd_q;
	logic [COUNT_W-1:0]  count_mem [MAX_CLASSES];
	logic [COUNT_W-1:0]  count_rd_q;

	logic [IDX_W-1:0]    rd_k_q;
	logic [IDX_W-1:0]    cmp_k_s1;
	logic                cmp_v_s1;
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    pick_q;
	logic [COUNT_W-1:0]  count_q;
	logic [IDX_W-1:0]    clr_k_q;
	logic [CLASS_W-1:0]  out_class_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [NW-1:0]       nc_w;
	logic [NW-1:0]       n_eff;
	logic [IDX_W-1:0]    last_d;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [PREFIX_W-1:0] prev_prefix;
	logic [SUM_W-1:0]    sum_w;
	logic [PREFIX_W-1:0] new_prefix;
	logic [COUNT_W-1:0]  count_inc;

	// Active class count: clamp to the table depth, zero counts as one.
	assign nc_w   = NW'(num_classes);
	assign n_eff  = (nc_w > MAX_N) ? MAX_N : ((nc_w == '0) ? NW'(1) : nc_w);
	assign last_d = IDX_W'(n_eff - NW'(1));

	assign wr_addr = IDX_W'(idx_q);
	assign rd_addr = cmd.scan ? rd_k_q : (IDX_W'(idx_q) - IDX_W'(1));

	assign prev_prefix = (idx_q == '0) ? '0 : prefix_rd_q;
	assign sum_w       = SUM_W'(weight_q) + SUM_W'(prev_prefix);
	assign new_prefix  = (sum_w > SUM_W'(PREFIX_ONE)) ? PREFIX_ONE : sum_w[PREFIX_W-1:0];

	assign count_inc = (count_rd_q == COUNT_MAX) ? count_rd_q : count_rd_q + COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_cmd;
			idx_q     <= in_class_index;
			weight_q  <= in_weight;
			uniform_q <= in_uniform;
		end
		if (cmd.scan_start) begin
			last_q <= last_d;
		end
		if (cmd.scan) begin
			cmp_k_s1 <= rd_k_q;
		end
		if (cmd.pick) begin
			pick_q <= cmp_k_s1;
		end
		if (cmd.cnt_wr) begin
			count_q <= count_inc;
		end
		if (cmd.push) begin
			out_class_q <= CLASS_W'(pick_q);
			out_count_q <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			prefix_mem[wr_addr] <= new_prefix;
		end
		prefix_rd_q <= prefix_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			count_mem[clr_k_q] <= '0;
		end else if (cmd.cnt_wr) begin
			count_mem[pick_q] <= count_inc;
		end
		count_rd_q <= count_mem[pick_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_k_q   <= '0;
			cmp_v_s1 <= 1'b0;
			clr_k_q  <= '0;
		end else begin
			if (cmd.scan_start) begin
				rd_k_q   <= '0;
				cmp_v_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_k_q   <= rd_k_q + IDX_W'(1);
				cmp_v_s1 <= 1'b1;
			end
			if (cmd.clr_start) begin
				clr_k_q <= '0;
			end else if (cmd.clr_step) begin
				clr_k_q <= clr_k_q + IDX_W'(1);
			end
		end
	end

	// The last active class always matches, so the scan ends there at the latest.
	assign status.hit      = cmp_v_s1 &&
		((PREFIX_W'(uniform_q) < prefix_rd_q) || (cmp_k_s1 == last_q));
	assign status.op       = op_q;
	assign status.load_ok  = (32'(idx_q) < MAX_U);
	assign status.clr_done = (clr_k_q == LAST_IDX);

	assign chosen_class = out_class_q;
	assign class_count  = out_count_q;

endmodule

`default_nettype wire

/* src/cs_ctrl.sv */
// Controller state machine of the categorical sampler: sequences load,
// draw and clear, and owns both channel handshakes. Depends on cs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cs_ctrl
	import cs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DECODE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_SCAN,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new beat replaces one that leaves in the same cycle
			if ((state_q == ST_PUSH) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (status.clr_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					case (status.op)
						CMD_LOAD:  state_q <= status.load_ok ? ST_LOAD_RD : ST_IDLE;
						CMD_DRAW:  state_q <= ST_SCAN;
						CMD_CLEAR: state_q <= ST_CLR;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_LOAD_RD: state_q <= ST_LOAD_WR;
				ST_LOAD_WR: state_q <= ST_IDLE;
				ST_SCAN: begin
					if (status.hit) state_q <= ST_CNT_RD;
				end
				ST_CNT_RD: state_q <= ST_CNT_WR;
				ST_CNT_WR: state_q <= ST_PUSH;
				ST_PUSH: begin
					// hold until the result register is free
					if (rsp_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && req_valid;
		cmd.scan_start = (state_q == ST_DECODE) && (status.op == CMD_DRAW);
		cmd.clr_start  = (state_q == ST_DECODE) && (status.op == CMD_CLEAR);
		cmd.clr_step   = (state_q == ST_CLR);
		cmd.load_wr    = (state_q == ST_LOAD_WR);
		cmd.scan       = (state_q == ST_SCAN);
		cmd.pick       = (state_q == ST_SCAN) && status.hit;
		cmd.cnt_wr     = (state_q == ST_CNT_WR);
		cmd.push       = (state_q == ST_PUSH) && rsp_free;
	end

endmodule

`default_nettype wire

/* src/cs_checker.sv */
// Port-level checker of the categorical sampler, bound to the top level.
// Depends on cs_pkg and categorical_sampler_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "categorical_sampler_top_defines.svh"

module cs_checker
	import cs_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [CLASS_W-1:0] chosen_class,
	input wire logic [COUNT_W-1:0] class_count
);

	`CS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_class) && $stable(class_count), "stalled result changed")
	`CS_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "second item accepted while one is in work")
	`CS_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> !$past(req_ready), "result appeared without a draw in work")
	`CS_ASSERT(a_count_nonzero, rsp_valid |-> class_count != '0, "delivered hit count is zero")

endmodule

bind categorical_sampler_top cs_checker u_cs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.chosen_class (rsp.chosen_class),
	.class_count  (rsp.class_count)
);

`default_nettype wire

/* tb/cs_tb_pkg.sv */
`timescale 1ns / 1ps
// Predictor for the categorical sampler bench: prefix table, per-class hit counters
// and the queue of draw results still owed by the block. Depends on cs_pkg.
package cs_tb_pkg;
	import cs_pkg::*;

	localparam int SAMPLER_CLASSES = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CLASS_W-1:0] cls;
		logic [COUNT_W-1:0] hits;
	} draw_outcome_t;

	class class_hit_ledger;
		logic [PREFIX_W-1:0]      cdf [SAMPLER_CLASSES];
		logic [COUNT_W-1:0]       hits [SAMPLER_CLASSES];
		logic [NUM_CLASSES_W-1:0] num_classes;
		draw_outcome_t            pending [$];
		int errors;
		int draws_checked;
		int loads_seen;
		int draws_seen;
		int clears_seen;
		int idle_ops;

		function new();
			foreach (cdf[i]) begin
				cdf[i] = '0;
				hits[i] = '0;
			end
			num_classes = NUM_CLASSES_RST;
			errors = 0;
			draws_checked = 0;
			loads_seen = 0;
			draws_seen = 0;
			clears_seen = 0;
			idle_ops = 0;
		endfunction

		// Zero and one both collapse to a single class; anything past the table clamps.
		function int active_classes();
			int n;
			n = num_classes;
			if (n > SAMPLER_CLASSES) n = SAMPLER_CLASSES;
			if (n == 0) n = 1;
			return n;
		endfunction

		task flag_mismatch(string what);
			errors++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		function void note_beat(logic [CMD_W-1:0] op, logic [CLASS_W-1:0] idx,
			logic [WEIGHT_W-1:0] w, logic [WEIGHT_W-1:0] u);
			logic [PREFIX_W:0] sum;
			int n;
			int pick;
			draw_outcome_t o;
			case (op)
				CMD_LOAD: begin
					sum = {2'b00, w};
					if (idx != 0) sum = sum + {1'b0, cdf[idx - 1'b1]};
					if (sum > {1'b0, PREFIX_ONE}) sum = {1'b0, PREFIX_ONE};
					cdf[idx] = sum[PREFIX_W-1:0];
					loads_seen++;
				end
				CMD_DRAW: begin
					n = active_classes();
					pick = n - 1;
					for (int k = 0; k < n - 1; k++) begin
						if ({1'b0, u} < cdf[k]) begin
							pick = k;
							break;
						end
					end
					if (hits[pick] != COUNT_MAX) hits[pick] = hits[pick] + 1'b1;
					o.cls = CLASS_W'(pick);
					o.hits = hits[pick];
					pending.push_back(o);
					draws_seen++;
				end
				CMD_CLEAR: begin
					foreach (hits[i]) hits[i] = '0;
					clears_seen++;
				end
				default: idle_ops++;
			endcase
		endfunction

		task check_draw(logic [CLASS_W-1:0] cls, logic [COUNT_W-1:0] cnt);
			draw_outcome_t o;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("result with nothing owed: class %0d count %0d", cls, cnt));
				return;
			end
			o = pending.pop_front();
			draws_checked++;
			if (cls !== o.cls)
				flag_mismatch($sformatf("chosen_class %0d, predicted %0d", cls, o.cls));
			if (cnt !== o.hits)
				flag_mismatch($sformatf("class_count %0d, predicted %0d (class %0d)",
					cnt, o.hits, o.cls));
		endtask
	endclass

endpackage

/* tb/tb_categorical_sampler_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for categorical_sampler_top: directed corners, then random
// load/draw/clear phases over many class counts. Depends on cs_pkg, cs_if, cs_tb_pkg.
module tb_categorical_sampler_top;
	import cs_pkg::*;
	import cs_tb_pkg::*;

	localparam int TARGET_ITEMS = 1400;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = SAMPLER_CLASSES + 8;
	localparam logic [ADDR_W-1:0] NUM_CLASSES_ADDR = ADDR_W'(4 * int'(REG_NUM_CLASSES));

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	cs_req_if req_ch ();
	cs_rsp_if rsp_ch ();

	categorical_sampler_top #(
		.MAX_CLASSES(SAMPLER_CLASSES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	class_hit_ledger ledger = new();
	bit planned_filled [SAMPLER_CLASSES];
	bit hold_pending = 1'b0;
	int burst_left = 0;
	int settings_done = 0;
	int rand_items = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			ledger.note_beat(req_ch.cmd, req_ch.class_index, req_ch.weight, req_ch.uniform);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			ledger.check_draw(rsp_ch.chosen_class, rsp_ch.class_count);
	end

	// Response side: switch stall pattern every so often; on request, hold off long.
	initial begin : rx_pacing
		int mode;
		int left;
		int cyc;
		rsp_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 4);
					left = $urandom_range(32, 256);
				end
				left--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
					3: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ((cyc % 7) >= 3);
				endcase
			end
		end
	end

	task send_beat(input logic [CMD_W-1:0] op, input logic [CLASS_W-1:0] idx,
		input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] u);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 10);
			end
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		if (op == CMD_LOAD) planned_filled[idx] = 1'b1;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.class_index <= idx;
		req_ch.weight <= w;
		req_ch.uniform <= u;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task send_load(input logic [CLASS_W-1:0] idx, input logic [WEIGHT_W-1:0] w);
		send_beat(CMD_LOAD, idx, w, WEIGHT_W'($urandom));
	endtask

	task send_draw(input logic [WEIGHT_W-1:0] u);
		send_beat(CMD_DRAW, CLASS_W'($urandom), WEIGHT_W'($urandom), u);
	endtask

	task send_other(input logic [CMD_W-1:0] op);
		send_beat(op, CLASS_W'($urandom), WEIGHT_W'($urandom), WEIGHT_W'($urandom));
	endtask

	// Drop valid, wait for every owed draw, then let a clear in flight finish.
	task settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task verify_classes();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= NUM_CLASSES_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== DATA_W'(ledger.num_classes))
			ledger.flag_mismatch($sformatf("num_classes reads %0d, last set %0d",
				prdata, ledger.num_classes));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task program_classes(input logic [NUM_CLASSES_W-1:0] val);
		logic [DATA_W-1:0] wr;
		wr = $urandom;
		wr[NUM_CLASSES_W-1:0] = val;
		apb_write(NUM_CLASSES_ADDR, wr);
		ledger.num_classes = val;
		settings_done++;
		verify_classes();
	endtask

	function automatic logic [WEIGHT_W-1:0] row_weight(int style, int m);
		int base;
		int v;
		base = 65536 / m;
		case (style)
			0: v = base - base / 4 + int'($urandom_range(0, base / 2));
			1: v = $urandom_range(0, 65535);
			2: v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) : 0;
			default: v = $urandom_range(0, 2 * base);
		endcase
		if (v > 65535) v = 65535;
		return WEIGHT_W'(v);
	endfunction

	// Aim some draws exactly at or just below a class boundary.
	function automatic logic [WEIGHT_W-1:0] draw_uniform(int m);
		int k;
		logic [PREFIX_W-1:0] p;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 16'hFFFF;
			2, 3: begin
				if (m < 2) return WEIGHT_W'($urandom);
				k = $urandom_range(0, m - 2);
				p = ledger.cdf[k];
				if (p >= PREFIX_ONE) return 16'hFFFF;
				if ($urandom_range(0, 1) == 1 && p != 0) p = p - 1'b1;
				return p[WEIGHT_W-1:0];
			end
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	task load_row(input int last, input int m, input int style);
		for (int k = 0; k <= last; k++) send_load(CLASS_W'(k), row_weight(style, m));
	endtask

	initial begin : stimulus
		int first_vals [8];
		int phase;
		int nval;
		int m;
		int ops;
		int r;
		int j;
		int k;
		first_vals = '{2, 64, 127, 65, 3, 1, 0, 17};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_LOAD;
		req_ch.class_index = '0;
		req_ch.weight = '0;
		req_ch.uniform = '0;
		foreach (planned_filled[i]) planned_filled[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset value, zero weight, saturating prefix, boundary hits,
		// clear, unused op, then the one-class settings.
		verify_classes();
		program_classes(NUM_CLASSES_W'(4));
		send_load(CLASS_W'(0), 16'h0000);
		send_load(CLASS_W'(1), 16'hFFFF);
		send_load(CLASS_W'(2), 16'hFFFF);
		send_load(CLASS_W'(3), 16'd1234);
		send_draw(16'h0000);
		send_draw(16'hFFFF);
		send_draw(16'hFFFE);
		send_other(CMD_CLEAR);
		send_draw(16'd100);
		send_other(CMD_UNUSED);
		send_load(CLASS_W'(0), 16'hFFFF);
		send_draw(16'hFFFF);
		settle();
		program_classes(NUM_CLASSES_W'(1));
		send_draw(WEIGHT_W'($urandom));
		send_draw(16'hFFFF);
		settle();
		program_classes(NUM_CLASSES_W'(0));
		send_draw(16'h0000);
		settle();

		phase = 0;
		while (rand_items < TARGET_ITEMS) begin
			if (phase < 8) nval = first_vals[phase];
			else if ($urandom_range(0, 3) == 0) nval = $urandom_range(0, 127);
			else nval = $urandom_range(2, 12);
			program_classes(NUM_CLASSES_W'(nval));
			m = ledger.active_classes();
			load_row(m - 1, m, $urandom_range(0, 3));
			rand_items += m;
			if (phase == 2 || phase == 9) hold_pending = 1'b1;
			ops = $urandom_range(40, 110);
			repeat (ops) begin
				r = $urandom_range(0, 99);
				if (r < 76) begin
					send_draw(draw_uniform(m));
					rand_items++;
				end else if (r < 84) begin
					j = $urandom_range(0, m - 1);
					load_row(j, m, $urandom_range(0, 3));
					rand_items += j + 1;
				end else if (r < 90) begin
					// Stray load: any class whose predecessor already holds a prefix.
					do k = $urandom_range(0, SAMPLER_CLASSES - 1);
					while (k != 0 && !planned_filled[k - 1]);
					send_load(CLASS_W'(k), WEIGHT_W'($urandom));
					rand_items++;
				end else if (r < 95) begin
					send_other(CMD_CLEAR);
					rand_items++;
				end else begin
					send_other(CMD_UNUSED);
				end
			end
			settle();
			phase++;
		end

		$display("Run: %0d loads, %0d draws (%0d results checked), %0d clears, %0d unused ops",
			ledger.loads_seen, ledger.draws_seen, ledger.draws_checked, ledger.clears_seen,
			ledger.idle_ops);
		$display("  over %0d class-count settings, with %0d-cycle response hold-offs",
			settings_done, HOLD_CYCLES);
		if (ledger.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
